// File: rtl/tpt_pkg.sv
// Shared types and constants of the touch-point tracker.
package tpt_pkg;

  localparam int unsigned MaxTracksDef = 16;
  localparam int unsigned MaxPointsDef = 16;
  localparam logic [7:0]  MaxDistReset = 8'd35;
  localparam int unsigned CoordW       = 12;
  localparam int unsigned IdentW       = 16;
  localparam int unsigned MaxEvents    = 32;
  localparam int unsigned EvCntW       = 6;

  typedef enum logic [1:0] {
    EV_UPDATE = 2'd0,
    EV_REMOVE = 2'd1,
    EV_ADD    = 2'd2
  } event_kind_e;

  typedef struct packed {
    logic [CoordW-1:0] point_x;
    logic [CoordW-1:0] point_y;
    logic              has_point;
    logic              frame_end;
  } point_req_t;

  typedef struct packed {
    logic [1:0]        event_kind;
    logic [IdentW-1:0] track_id;
    logic [CoordW-1:0] track_x;
    logic [CoordW-1:0] track_y;
    logic              last_event;
  } event_req_t;

  // Request passed from the front end to the matcher
  typedef struct packed {
    logic              has_point;
    logic              frame_end;
    logic [CoordW-1:0] px;
    logic [CoordW-1:0] py;
  } cmd_t;

endpackage

// File: rtl/tpt_if.sv
// Valid/ready channel interface carrying one request.
interface tpt_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/touch_point_tracker.sv
// Touch-point tracker top level: front queue and matcher.
//
// Usage: in_ch carries one point per request (point_x, point_y, has_point)
// and frame_end closes a frame. Requests with neither flag are dropped.
// At frame end the matcher walks every valid track against every unused
// point and emits update/remove events, then add events for leftover points,
// on out_ch; the final event of a frame has last_event set.
// A point request is registered in the front queue and then stored by the
// matcher. A frame end walks the tracks and points through the single shared
// distance unit (one squarer pair). Each event leaves once the next one is
// formed or the walk ends, so the last flag is known. max_dist is written
// through cfg_we_i/cfg_wdata_i; the user must write it only while idle, and
// the block itself does not enforce this. Reset value 35. Reset empties the
// track table and point list, ident restarts at 1. When out_ch stalls the
// matcher holds its walk; the two-entry front queue keeps taking requests
// until full.
module touch_point_tracker #(
  parameter int unsigned MaxTracks = tpt_pkg::MaxTracksDef,
  parameter int unsigned MaxPoints = tpt_pkg::MaxPointsDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i,
  tpt_if.sink        in_ch,
  tpt_if.source      out_ch
);
  import tpt_pkg::*;

  logic       max_dist_q;
  logic [7:0] dist_q;
  logic       cmd_valid, cmd_ready;
  cmd_t       cmd;

  // Hold the distance register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dist_q     <= MaxDistReset;
      max_dist_q <= 1'b0;
    end else if (cfg_we_i) begin
      dist_q     <= cfg_wdata_i;
      max_dist_q <= 1'b1;
    end
  end

  tpt_front u_front (
    .clk_i, .rst_ni, .in_ch,
    .cmd_valid_o(cmd_valid), .cmd_o(cmd), .cmd_ready_i(cmd_ready)
  );

  tpt_match #(.MaxTracks(MaxTracks), .MaxPoints(MaxPoints)) u_match (
    .clk_i, .rst_ni, .max_dist_i(dist_q),
    .cmd_valid_i(cmd_valid), .cmd_i(cmd), .cmd_ready_o(cmd_ready), .out_ch
  );

`ifndef ASSERT_OFF
  a_cfg_seen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> max_dist_q && dist_q == $past(cfg_wdata_i)) else $error("cfg lost");
`endif
endmodule

// File: rtl/tpt_front.sv
// Front end: classify input requests and queue them for the matcher.
module tpt_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  tpt_if.sink            in_ch,
  output logic           cmd_valid_o,
  output tpt_pkg::cmd_t  cmd_o,
  input  logic           cmd_ready_i
);
  import tpt_pkg::*;

  localparam int unsigned Depth = 2;

  cmd_t       fifo_q [Depth];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       push, pop, useful;

  // Drop requests with neither a point nor a frame end
  assign useful      = in_ch.data.has_point | in_ch.data.frame_end;
  assign in_ch.ready = (cnt_q != 2'd2);
  assign push        = in_ch.valid & in_ch.ready & useful;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign pop         = cmd_valid_o & cmd_ready_i;
  assign cmd_o       = fifo_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wp_q] <= '{has_point: in_ch.data.has_point, frame_end: in_ch.data.frame_end,
                        px: in_ch.data.point_x, py: in_ch.data.point_y};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop)  rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == 2'd2 |-> !push) else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == 2'd0 |-> !pop) else $error("queue underflow");
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3) else $error("queue count out of range");
`endif
endmodule

// File: rtl/tpt_match.sv
// Back end: store points, match tracks at frame end and emit events.
module tpt_match #(
  parameter int unsigned MaxTracks = tpt_pkg::MaxTracksDef,
  parameter int unsigned MaxPoints = tpt_pkg::MaxPointsDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [7:0]    max_dist_i,
  input  logic          cmd_valid_i,
  input  tpt_pkg::cmd_t cmd_i,
  output logic          cmd_ready_o,
  tpt_if.source         out_ch
);
  import tpt_pkg::*;

  localparam int unsigned TW = (MaxTracks > 1) ? $clog2(MaxTracks) : 1;
  localparam int unsigned PW = (MaxPoints > 1) ? $clog2(MaxPoints) : 1;
  localparam int unsigned PCW = $clog2(MaxPoints + 1);
  localparam int unsigned TCW = $clog2(MaxTracks + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_TRK, S_SCAN, S_DIST, S_DEC, S_ADD, S_EMIT, S_DONE
  } state_e;

  state_e              state_q;
  logic [MaxTracks-1:0] tvalid_q;
  logic [IdentW-1:0]    tid_q  [MaxTracks];
  logic [2*CoordW-1:0]  tpos_q [MaxTracks];
  logic [2*CoordW-1:0]  pts_q  [MaxPoints];
  logic [MaxPoints-1:0] used_q;
  logic [PCW-1:0]       pcnt_q;
  logic [IdentW-1:0]    nid_q;
  logic [TCW-1:0]       t_q;
  logic [PCW-1:0]       p_q;
  logic [PW-1:0]        best_q;
  logic                 found_q;
  logic [24:0]          bestd_q, dx2_q, dy2_q;
  logic [15:0]          limit_q;
  logic                 ret_add_q;
  event_req_t           ev_q, pend_q, nxt_q;
  logic                 ovalid_q, pend_v_q;
  logic [EvCntW-1:0]    nev_q;

  logic [CoordW:0]      dx, dy;
  logic [2*CoordW-1:0]  tp, pp;
  logic [24:0]          dsum;
  logic                 free_any;
  logic [TW-1:0]        free_t;
  event_req_t           ev_out;
  logic                 emit_go, ev_load;

  assign tp   = tpos_q[t_q[TW-1:0]];
  assign pp   = pts_q[p_q[PW-1:0]];
  assign dx   = {1'b0, tp[CoordW-1:0]} - {1'b0, pp[CoordW-1:0]};
  assign dy   = {1'b0, tp[2*CoordW-1:CoordW]} - {1'b0, pp[2*CoordW-1:CoordW]};
  assign dsum = dx2_q + dy2_q;

  // Lowest free slot of the table
  always_comb begin
    free_any = 1'b0;
    free_t   = '0;
    for (int i = MaxTracks - 1; i >= 0; i--) begin
      if (!tvalid_q[i]) begin
        free_any = 1'b1;
        free_t   = TW'(i);
      end
    end
  end

  // Release the held event once the output register is free
  assign emit_go = ((state_q == S_EMIT) || (state_q == S_DONE)) &&
                   (!pend_v_q || !ovalid_q || out_ch.ready);
  assign ev_load = emit_go && pend_v_q && (nev_q <= EvCntW'(MaxEvents));

  // Mark the last reported event of the frame
  always_comb begin
    ev_out            = pend_q;
    ev_out.last_event = (state_q == S_DONE) || (nev_q == EvCntW'(MaxEvents));
  end

  assign cmd_ready_o  = (state_q == S_IDLE);
  assign out_ch.valid = ovalid_q;
  assign out_ch.data  = ev_q;

  always_ff @(posedge clk_i) begin
    dx2_q <= 25'($signed(dx) * $signed(dx));
    dy2_q <= 25'($signed(dy) * $signed(dy));
  end

  // Sequencer: one step of the track/point walk per cycle, holding in the emit states while the output stalls
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      tvalid_q  <= '0;
      used_q    <= '0;
      pcnt_q    <= '0;
      nid_q     <= IdentW'(1);
      ovalid_q  <= 1'b0;
      pend_v_q  <= 1'b0;
      t_q       <= '0;
      p_q       <= '0;
      nev_q     <= '0;
      found_q   <= 1'b0;
      ret_add_q <= 1'b0;
    end else begin
      ovalid_q <= ev_load | (ovalid_q & ~out_ch.ready);
      if (ev_load) ev_q <= ev_out;
      unique case (state_q)
        S_IDLE: begin
          if (cmd_valid_i) begin
            logic [PCW-1:0] nc;
            nc = pcnt_q;
            if (cmd_i.has_point && pcnt_q < PCW'(MaxPoints)) begin
              pts_q[pcnt_q[PW-1:0]]  <= {cmd_i.py, cmd_i.px};
              used_q[pcnt_q[PW-1:0]] <= 1'b0;
              nc = pcnt_q + 1'b1;
            end
            pcnt_q <= nc;
            if (cmd_i.frame_end) begin
              limit_q  <= 16'(max_dist_i * max_dist_i);
              t_q      <= '0;
              nev_q    <= '0;
              pend_v_q <= 1'b0;
              state_q  <= S_TRK;
            end
          end
        end
        S_TRK: begin
          if (t_q == TCW'(MaxTracks)) begin
            p_q     <= '0;
            state_q <= S_ADD;
          end else if (!tvalid_q[t_q[TW-1:0]]) begin
            t_q <= t_q + 1'b1;
          end else begin
            p_q     <= '0;
            found_q <= 1'b0;
            bestd_q <= '0;
            state_q <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (p_q == pcnt_q) begin
            state_q <= S_DEC;
          end else if (used_q[p_q[PW-1:0]]) begin
            p_q <= p_q + 1'b1;
          end else begin
            state_q <= S_DIST;
          end
        end
        S_DIST: begin
          if (dsum <= {9'd0, limit_q} && (!found_q || dsum <= bestd_q)) begin
            found_q <= 1'b1;
            best_q  <= p_q[PW-1:0];
            bestd_q <= dsum;
          end
          p_q     <= p_q + 1'b1;
          state_q <= S_SCAN;
        end
        S_DEC: begin
          if (found_q) begin
            used_q[best_q]           <= 1'b1;
            tpos_q[t_q[TW-1:0]]      <= pts_q[best_q];
            nxt_q <= '{event_kind: EV_UPDATE, track_id: tid_q[t_q[TW-1:0]],
                       track_x: pts_q[best_q][CoordW-1:0],
                       track_y: pts_q[best_q][2*CoordW-1:CoordW], last_event: 1'b0};
          end else begin
            tvalid_q[t_q[TW-1:0]] <= 1'b0;
            nxt_q <= '{event_kind: EV_REMOVE, track_id: tid_q[t_q[TW-1:0]],
                       track_x: '0, track_y: '0, last_event: 1'b0};
          end
          t_q       <= t_q + 1'b1;
          ret_add_q <= 1'b0;
          state_q   <= S_EMIT;
        end
        S_ADD: begin
          if (p_q == pcnt_q || !free_any) begin
            state_q <= S_DONE;
          end else if (used_q[p_q[PW-1:0]]) begin
            p_q <= p_q + 1'b1;
          end else begin
            tvalid_q[free_t] <= 1'b1;
            tid_q[free_t]    <= nid_q;
            tpos_q[free_t]   <= pp;
            nxt_q <= '{event_kind: EV_ADD, track_id: nid_q, track_x: pp[CoordW-1:0],
                       track_y: pp[2*CoordW-1:CoordW], last_event: 1'b0};
            nid_q     <= (nid_q == '1) ? IdentW'(1) : nid_q + 1'b1;
            p_q       <= p_q + 1'b1;
            ret_add_q <= 1'b1;
            state_q   <= S_EMIT;
          end
        end
        S_EMIT: begin
          // Hold the previous event until the new one is known not to be last
          if (emit_go) begin
            pend_q   <= nxt_q;
            pend_v_q <= 1'b1;
            if (nev_q <= EvCntW'(MaxEvents)) nev_q <= nev_q + 1'b1;
            state_q  <= ret_add_q ? S_ADD : S_TRK;
          end
        end
        S_DONE: begin
          if (emit_go) begin
            pend_v_q <= 1'b0;
            pcnt_q   <= '0;
            used_q   <= '0;
            state_q  <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_ident_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    nid_q != '0) else $error("identifier zero");
  a_pcnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pcnt_q <= PCW'(MaxPoints)) else $error("point count overflow");
  a_ev_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovalid_q && !out_ch.ready |=> ovalid_q && $stable(ev_q)) else $error("event lost");
  a_idle_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE |-> !pend_v_q) else $error("pending event at idle");
`endif
endmodule

// File: verif/touch_point_tracker_tb.sv
// Self-checking testbench for the touch-point tracker: directed and random frames against a built-in tracker model.
module touch_point_tracker_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tpt_pkg::*;

  localparam int unsigned NumTracks = MaxTracksDef;
  localparam int unsigned NumPoints = MaxPointsDef;
  localparam int unsigned SettleCycles = 800;
  localparam int unsigned QuietLimit = 20000;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [7:0] cfg_wdata_i;

  tpt_if #(.payload_t(point_req_t)) pt_ch ();
  tpt_if #(.payload_t(event_req_t)) ev_ch ();

  touch_point_tracker dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_ch      (pt_ch),
    .out_ch     (ev_ch)
  );

  // Tracker model state
  logic              tbl_valid [NumTracks];
  logic [IdentW-1:0] tbl_id    [NumTracks];
  logic [CoordW-1:0] tbl_x     [NumTracks];
  logic [CoordW-1:0] tbl_y     [NumTracks];
  logic [CoordW-1:0] pt_x      [NumPoints];
  logic [CoordW-1:0] pt_y      [NumPoints];
  logic              pt_used   [NumPoints];
  int unsigned       pt_cnt;
  logic [IdentW-1:0] id_next;
  logic [7:0]        dist_lim;

  point_req_t  pending_reqs [$];
  event_req_t  expected_events [$];
  int unsigned mismatches;
  bit          in_taken;
  bit          no_idle;
  int unsigned in_gap;
  int unsigned out_stall;
  int unsigned quiet;

  // Clock
  initial clk_i = 1'b0;
  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Mostly short gaps, now and then a long one
  function automatic int unsigned draw_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic void add_event(ref event_req_t evs[$], input logic [1:0] kind,
                                    input logic [IdentW-1:0] id,
                                    input logic [CoordW-1:0] x, input logic [CoordW-1:0] y);
    event_req_t ev;
    if (evs.size() >= MaxEvents) return;
    ev.event_kind = kind;
    ev.track_id   = id;
    ev.track_x    = x;
    ev.track_y    = y;
    ev.last_event = 1'b0;
    evs.insert(evs.size(), ev);
  endfunction

  // Load the point, then on frame end match tracks greedily and add leftovers
  function automatic void track_request(point_req_t r);
    event_req_t  evs [$];
    int unsigned lim, d, best_d, best, t;
    int          dx, dy;
    bit          found;
    if (r.has_point && pt_cnt < NumPoints) begin
      pt_x[pt_cnt]    = r.point_x;
      pt_y[pt_cnt]    = r.point_y;
      pt_used[pt_cnt] = 1'b0;
      pt_cnt++;
    end
    if (!r.frame_end) return;
    lim = int'(dist_lim) * int'(dist_lim);
    for (int unsigned k = 0; k < NumTracks; k++) begin
      if (!tbl_valid[k]) continue;
      found = 0;
      best = 0;
      best_d = 0;
      for (int unsigned p = 0; p < pt_cnt; p++) begin
        if (pt_used[p]) continue;
        dx = int'(tbl_x[k]) - int'(pt_x[p]);
        dy = int'(tbl_y[k]) - int'(pt_y[p]);
        d = dx * dx + dy * dy;
        if (d <= lim && (!found || d <= best_d)) begin
          found = 1;
          best = p;
          best_d = d;
        end
      end
      if (found) begin
        pt_used[best] = 1'b1;
        tbl_x[k] = pt_x[best];
        tbl_y[k] = pt_y[best];
        add_event(evs, EV_UPDATE, tbl_id[k], tbl_x[k], tbl_y[k]);
      end else begin
        tbl_valid[k] = 1'b0;
        add_event(evs, EV_REMOVE, tbl_id[k], '0, '0);
      end
    end
    for (int unsigned p = 0; p < pt_cnt; p++) begin
      if (pt_used[p]) continue;
      t = 0;
      while (t < NumTracks && tbl_valid[t]) t++;
      if (t >= NumTracks) break;
      tbl_valid[t] = 1'b1;
      tbl_id[t] = id_next;
      tbl_x[t] = pt_x[p];
      tbl_y[t] = pt_y[p];
      add_event(evs, EV_ADD, id_next, pt_x[p], pt_y[p]);
      id_next = (id_next == 16'hFFFF) ? 16'd1 : id_next + 16'd1;
    end
    pt_cnt = 0;
    for (int unsigned p = 0; p < NumPoints; p++) pt_used[p] = 1'b0;
    if (evs.size() > 0) evs[evs.size()-1].last_event = 1'b1;
    foreach (evs[i]) expected_events.insert(expected_events.size(), evs[i]);
  endfunction

  // Input driver: record accepted requests at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni && pt_ch.valid && pt_ch.ready) begin
      track_request(pt_ch.data);
      in_taken = 1;
    end
  end

  // Input driver: advance to the next request at the falling edge
  always @(negedge clk_i) begin
    if (rst_ni && (!pt_ch.valid || in_taken)) begin
      in_taken = 0;
      if (in_gap > 0) begin
        in_gap--;
        pt_ch.valid = 1'b0;
      end else if (pending_reqs.size() > 0) begin
        pt_ch.data  = pending_reqs.pop_front();
        pt_ch.valid = 1'b1;
        in_gap      = draw_gap();
      end else begin
        pt_ch.valid = 1'b0;
      end
    end
  end

  // Output side: stall ready at random
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (out_stall > 0) begin
        out_stall--;
        ev_ch.ready = 1'b0;
      end else begin
        ev_ch.ready = 1'b1;
        if ($urandom_range(0, 99) < 25) out_stall = draw_gap();
      end
    end
  end

  // Monitor: compare each accepted event with the oldest expectation
  always @(posedge clk_i) begin
    event_req_t want;
    event_req_t got;
    if (rst_ni && ev_ch.valid && ev_ch.ready) begin
      got = ev_ch.data;
      if (expected_events.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected event: kind %0d id %0d x %0d y %0d last %0d",
                   got.event_kind, got.track_id, got.track_x, got.track_y, got.last_event);
      end else begin
        want = expected_events.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("event mismatch: expected kind %0d id %0d x %0d y %0d last %0d, got kind %0d id %0d x %0d y %0d last %0d",
                     want.event_kind, want.track_id, want.track_x, want.track_y,
                     want.last_event, got.event_kind, got.track_id, got.track_x,
                     got.track_y, got.last_event);
        end
      end
    end
  end

  // Watchdog on cycles with no request moving on either side
  always @(posedge clk_i) begin
    if ((pt_ch.valid && pt_ch.ready) || (ev_ch.valid && ev_ch.ready)) quiet = 0;
    else quiet++;
    if (quiet >= QuietLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic void queue_req(int unsigned x, int unsigned y, bit hp, bit fe);
    point_req_t r;
    r.point_x   = x[CoordW-1:0];
    r.point_y   = y[CoordW-1:0];
    r.has_point = hp;
    r.frame_end = fe;
    pending_reqs.insert(pending_reqs.size(), r);
  endfunction

  // Hold until all requests and events have moved, then let the matcher settle
  task automatic drain();
    while (pending_reqs.size() > 0 || pt_ch.valid || expected_events.size() > 0)
      @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic set_max_dist(logic [7:0] v);
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_wdata_i = v;
    dist_lim    = v;
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
  endtask

  function automatic int unsigned clip(int v);
    if (v < 0) return 0;
    if (v > 4095) return 4095;
    return v;
  endfunction

  // One well-formed frame: points near live tracks plus a few fresh ones
  function automatic void queue_frame(int unsigned npts);
    int unsigned k, j;
    bit          fe_with_pt;
    fe_with_pt = $urandom_range(0, 1);
    j = dist_lim / 2 + 2;
    for (int unsigned i = 0; i < npts; i++) begin
      k = $urandom_range(0, NumTracks - 1);
      if (tbl_valid[k] && $urandom_range(0, 3) != 0)
        queue_req(clip(int'(tbl_x[k]) + $urandom_range(0, 2 * j) - j),
                  clip(int'(tbl_y[k]) + $urandom_range(0, 2 * j) - j), 1,
                  fe_with_pt && i == npts - 1);
      else
        queue_req($urandom_range(0, 4095), $urandom_range(0, 4095), 1,
                  fe_with_pt && i == npts - 1);
    end
    if (!fe_with_pt || npts == 0) queue_req($urandom, $urandom, 0, 1);
  endfunction

  // Random frames; model is only read ahead by a frame, so wait per frame and drain at the end
  task automatic random_phase(int unsigned nframes);
    int unsigned r;
    for (int unsigned f = 0; f < nframes; f++) begin
      r = $urandom_range(0, 99);
      if (r < 8) queue_req($urandom, $urandom, 0, 0);
      if (r < 4) queue_frame($urandom_range(15, 19));
      else queue_frame($urandom_range(0, 6));
      while (pending_reqs.size() > 0 || pt_ch.valid) @(posedge clk_i);
    end
    drain();
  endtask

  initial begin
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    pt_ch.valid = 1'b0;
    pt_ch.data  = '0;
    ev_ch.ready = 1'b0;
    mismatches  = 0;
    in_taken    = 0;
    in_gap      = 0;
    out_stall   = 0;
    quiet       = 0;
    no_idle     = 0;
    for (int unsigned k = 0; k < NumTracks; k++) begin
      tbl_valid[k] = 1'b0;
      tbl_id[k] = '0;
      tbl_x[k] = '0;
      tbl_y[k] = '0;
    end
    for (int unsigned p = 0; p < NumPoints; p++) begin
      pt_x[p] = '0;
      pt_y[p] = '0;
      pt_used[p] = 1'b0;
    end
    pt_cnt   = 0;
    id_next  = 16'd1;
    dist_lim = MaxDistReset;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: corners, point on frame end, ties, ignored and empty requests
    queue_req(0, 0, 0, 1);
    queue_req(0, 0, 1, 0);
    queue_req(4095, 4095, 1, 0);
    queue_req(100, 100, 1, 0);
    queue_req(4095, 0, 1, 1);
    queue_req(4095, 4095, 0, 0);
    queue_req(110, 100, 1, 0);
    queue_req(90, 100, 1, 0);
    queue_req(35, 0, 0, 0);
    queue_req(21, 28, 1, 0);
    queue_req(0, 4095, 1, 0);
    queue_req(0, 0, 0, 1);
    queue_req(0, 0, 0, 1);
    queue_req(0, 0, 0, 1);
    drain();

    // Random frames under several distance limits
    random_phase(12);
    set_max_dist(8'd0);
    random_phase(8);
    set_max_dist(8'd255);
    random_phase(8);
    no_idle = 1;
    set_max_dist(8'($urandom_range(1, 254)));
    random_phase(6);
    no_idle = 0;
    set_max_dist(MaxDistReset);
    random_phase(6);
    set_max_dist(8'($urandom_range(0, 255)));
    random_phase(4);

    if (mismatches == 0 && expected_events.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
